// File: hw/rtl/tbaid_pkg.sv
// ----------------------------------------------------------------------------
// tbaid_pkg
// Shared types and codes for the spanning-tree build and ID assignment node:
// message payloads, opcode and result kind codes, configuration indexes.
// ----------------------------------------------------------------------------
package tbaid_pkg;

  localparam int VAL_W   = 11;
  localparam int PORT_W  = 3;
  localparam int CODE_W  = 3;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 1;

  // Incoming message opcodes
  localparam logic [CODE_W-1:0] OP_START   = 3'd0;
  localparam logic [CODE_W-1:0] OP_EXPLORE = 3'd1;
  localparam logic [CODE_W-1:0] OP_CONFIRM = 3'd2;
  localparam logic [CODE_W-1:0] OP_REJECT  = 3'd3;
  localparam logic [CODE_W-1:0] OP_REPORT  = 3'd4;
  localparam logic [CODE_W-1:0] OP_ASSIGN  = 3'd5;

  // Outgoing message kinds
  localparam logic [CODE_W-1:0] KIND_EXPLORE = 3'd0;
  localparam logic [CODE_W-1:0] KIND_CONFIRM = 3'd1;
  localparam logic [CODE_W-1:0] KIND_REJECT  = 3'd2;
  localparam logic [CODE_W-1:0] KIND_REPORT  = 3'd3;
  localparam logic [CODE_W-1:0] KIND_ASSIGN  = 3'd4;
  localparam logic [CODE_W-1:0] KIND_OWN_ID  = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IS_LEADER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECTED = 1'd1;

  typedef struct packed {
    logic [CODE_W-1:0] opcode;
    logic [PORT_W-1:0] port;
    logic [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0] kind;
    logic [PORT_W-1:0] out_port;
    logic [VAL_W-1:0]  out_value;
    logic              last;
  } rsp_t;

  // Sequencer to emitter control
  typedef struct packed {
    logic push;
    logic flush;
  } emit_ctl_t;

endpackage

// File: hw/rtl/tbaid_emit.sv
// ----------------------------------------------------------------------------
// tbaid_emit
// Result emitter: holds the newest message back by one so that the final
// message of an item can be marked last, and drives the output register.
// ----------------------------------------------------------------------------
module tbaid_emit
  import tbaid_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  emit_ctl_t ctl,
  input  rsp_t      item,
  output logic      ready,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_t      rsp
);

  logic hold_valid;
  rsp_t hold;
  logic out_free;
  logic load_out;

  // Output register can take a new message when empty or transferring
  assign out_free = !rsp_valid || !rsp_stall;
  assign ready    = !hold_valid || out_free;
  assign load_out = hold_valid && out_free && (ctl.push || ctl.flush);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (ctl.push && ready) begin
        hold_valid <= 1'b1;
      end else if (ctl.flush && ready) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // Payload: advance the held message, mark last on flush
  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp <= '{kind: hold.kind, out_port: hold.out_port, out_value: hold.out_value,
               last: ctl.flush};
    end
    if (ctl.push && ready) begin
      hold <= item;
    end
  end

endmodule

// File: hw/rtl/tree_build_and_id_assign_node_unit.sv
// ----------------------------------------------------------------------------
// tree_build_and_id_assign_node_unit
// Per-node engine of an echo spanning-tree build with subtree-size reporting
// and consecutive ID assignment.
// ----------------------------------------------------------------------------
// One message is taken at a time; req_stall stays high until every message it
// causes has been handed to the output register. A small sequencer walks the
// ports one per cycle while the emitter can take messages, sending explores
// over the pending ports and, at the root or on an assign, one ID range per
// child, with a single saturating adder shared for subtree sizes and ID ranges.
// An item passes through the execute step, then as needed the explore scan,
// the completion check, the own-ID step and the assign scan, and ends in the
// done step; the output side can hold any step that sends a message, and done.
// The user must write configuration through cfg_we/cfg_index/cfg_data only
// while the node is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tree_build_and_id_assign_node_unit
  import tbaid_pkg::*;
#(
  parameter int PORTS     = 6,
  parameter int MAX_NODES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SW = $clog2(MAX_NODES + 1);
  localparam int AW = ((SW > VAL_W) ? SW : VAL_W) + 1;
  localparam int IW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(PORTS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_EXPL  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_OWNID = 7'b0010000,
    S_ASGN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  function automatic logic [SW-1:0] sat(input logic [AW-1:0] x);
    return (x > AW'(MAX_NODES)) ? SW'(MAX_NODES) : SW'(x);
  endfunction

  state_t            state;
  logic              is_leader;
  logic [CFG_W-1:0]  connected_ports;
  logic              discovered;
  logic [PORT_W-1:0] parent_port;
  logic [PORTS-1:0]  pending_ports;
  logic [PORTS-1:0]  child_ports;
  logic [PORTS-1:0]  reported_ports;
  logic [SW-1:0]     child_sizes [PORTS];
  logic [SW-1:0]     own_subtree_size;
  logic              size_sent;

  logic [CODE_W-1:0] op;
  logic [PORT_W-1:0] port;
  logic [SW-1:0]     val;
  logic [SW-1:0]     acc;
  logic [IW-1:0]     cnt;

  logic              accept;
  logic              port_ok;
  logic [PORTS-1:0]  port_bit;
  logic [PORTS-1:0]  pend_clr;
  logic [IW-1:0]     pidx;
  logic              done_ok;
  logic [SW-1:0]     opa;
  logic [SW-1:0]     opb;
  logic [SW-1:0]     sum_sat;
  logic              push;
  logic              step;
  logic              emit_ready;
  rsp_t              item;
  emit_ctl_t         ctl;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign port_ok  = ({1'b0, port} < 4'(PORTS));
  assign port_bit = PORTS'(1) << port;
  assign pend_clr = pending_ports & ~port_bit;
  assign pidx     = IW'(port);
  assign done_ok  = !size_sent && discovered && (pending_ports == '0) &&
                    ((child_ports & ~reported_ports) == '0);

  // Shared saturating adder: subtree size, own id step, id ranges
  assign opa     = (state == S_EXEC) ? own_subtree_size : acc;
  assign opb     = (state == S_EXEC) ? val :
                   (state == S_OWNID) ? SW'(1) : child_sizes[cnt];
  assign sum_sat = sat(AW'(opa) + AW'(opb));

  // Message produced in the current sequencer step
  always_comb begin
    push = 1'b0;
    item = '{kind: KIND_EXPLORE, out_port: '0, out_value: '0, last: 1'b0};
    unique case (state)
      S_EXEC: begin
        if (op == OP_EXPLORE && port_ok) begin
          push          = 1'b1;
          item.kind     = (discovered || is_leader) ? KIND_REJECT : KIND_CONFIRM;
          item.out_port = port;
        end
      end
      S_EXPL: begin
        if (pending_ports[cnt]) begin
          push          = 1'b1;
          item.out_port = PORT_W'(cnt);
        end
      end
      S_CHECK: begin
        if (done_ok && !is_leader) begin
          push           = 1'b1;
          item.kind      = KIND_REPORT;
          item.out_port  = parent_port;
          item.out_value = VAL_W'(own_subtree_size);
        end
      end
      S_OWNID: begin
        push           = 1'b1;
        item.kind      = KIND_OWN_ID;
        item.out_value = VAL_W'(acc);
      end
      S_ASGN: begin
        if (child_ports[cnt]) begin
          push           = 1'b1;
          item.kind      = KIND_ASSIGN;
          item.out_port  = PORT_W'(cnt);
          item.out_value = VAL_W'(acc);
        end
      end
      default: ;
    endcase
  end

  assign step      = !push || emit_ready;
  assign ctl.push  = push && emit_ready;
  assign ctl.flush = (state == S_DONE);

  tbaid_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .item      (item),
    .ready     (emit_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      is_leader       <= 1'b0;
      connected_ports <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IS_LEADER: is_leader       <= cfg_data[0];
        REG_CONNECTED: connected_ports <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and node state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      discovered       <= 1'b0;
      parent_port      <= '0;
      pending_ports    <= '0;
      child_ports      <= '0;
      reported_ports   <= '0;
      own_subtree_size <= SW'(1);
      size_sent        <= 1'b0;
      for (int i = 0; i < PORTS; i++) begin
        child_sizes[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (step) begin
            if (op == OP_START) begin
              if (!discovered) begin
                pending_ports <= PORTS'(connected_ports);
              end
              if (!discovered && is_leader) begin
                discovered <= 1'b1;
                state      <= S_EXPL;
              end else begin
                state <= S_DONE;
              end
            end else if (!port_ok) begin
              state <= S_DONE;
            end else begin
              unique case (op)
                OP_EXPLORE: begin
                  if (discovered || is_leader) begin
                    state <= S_DONE;
                  end else begin
                    discovered    <= 1'b1;
                    parent_port   <= port;
                    pending_ports <= pend_clr;
                    state         <= (pend_clr == '0) ? S_CHECK : S_EXPL;
                  end
                end
                OP_CONFIRM: begin
                  pending_ports     <= pend_clr;
                  child_ports       <= child_ports | port_bit;
                  reported_ports    <= reported_ports & ~port_bit;
                  child_sizes[pidx] <= '0;
                  state             <= S_CHECK;
                end
                OP_REJECT: begin
                  pending_ports <= pend_clr;
                  state         <= S_CHECK;
                end
                OP_REPORT: begin
                  if ((child_ports & port_bit) != '0 &&
                      (reported_ports & port_bit) == '0) begin
                    reported_ports    <= reported_ports | port_bit;
                    child_sizes[pidx] <= val;
                    own_subtree_size  <= sum_sat;
                  end
                  state <= S_CHECK;
                end
                OP_ASSIGN: state <= S_OWNID;
                default:   state <= S_DONE;
              endcase
            end
          end
        end
        S_EXPL: begin
          if (step && cnt == LAST_IDX) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (step) begin
            if (done_ok) begin
              size_sent <= 1'b1;
              state     <= is_leader ? S_OWNID : S_DONE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_OWNID: begin
          if (step) begin
            state <= S_ASGN;
          end
        end
        S_ASGN: begin
          if (step && cnt == LAST_IDX) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (emit_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item registers, scan pointer and id accumulator
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op   <= req.opcode;
          port <= req.port;
          val  <= sat(AW'(req.value));
        end
      end
      S_EXEC: begin
        if (step) begin
          cnt <= '0;
          acc <= val;
        end
      end
      S_CHECK: begin
        acc <= '0;
      end
      S_OWNID: begin
        if (step) begin
          acc <= sum_sat;
          cnt <= '0;
        end
      end
      S_EXPL: begin
        if (step) begin
          cnt <= cnt + IW'(1);
        end
      end
      S_ASGN: begin
        if (step) begin
          cnt <= cnt + IW'(1);
          if (child_ports[cnt]) begin
            acc <= sum_sat;
          end
        end
      end
      default: ;
    endcase
  end

  // Size report happens once and only after discovery; reports only from children; parent stays fixed
  a_size_sent_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(size_sent))
    else $error("size_sent cleared outside reset");

  a_sent_needs_discovery: assert property (@(posedge clk) disable iff (rst)
    size_sent |-> discovered)
    else $error("size sent by an undiscovered node");

  a_reported_are_children: assert property (@(posedge clk) disable iff (rst)
    (reported_ports & ~child_ports) == '0)
    else $error("report recorded for a port that is not a child");

  a_parent_fixed: assert property (@(posedge clk) disable iff (rst)
    discovered && $past(discovered) |-> $stable(parent_port))
    else $error("parent port changed after discovery");

endmodule
